// ===== design/crc16_frame_appender_top_assert.svh =====
// Assertion macros for the CRC-16 frame appender back end.
`ifndef CRC16_FRAME_APPENDER_TOP_ASSERT_SVH
`define CRC16_FRAME_APPENDER_TOP_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define CRCFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define CRCFA_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/crcfa_pkg.sv =====
// Package: types, constants and CRC step function for the frame appender.
`timescale 1ns / 1ps
package crcfa_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h8005;
  localparam logic [15:0] CRC_INIT_RST   = 16'hFFFF;
  localparam int          QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        eof;
    logic [15:0] crc;
  } crcfa_entry_t;

  // One byte through the CRC-16, MSB first, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/crcfa_front.sv =====
// Front end: takes input beats, runs the CRC and queues each byte with its CRC.
`timescale 1ns / 1ps
module crcfa_front
  import crcfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_crc_init_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   data_byte_i,
  input  logic         end_of_frame_i,
  output logic         push_valid_o,
  output crcfa_entry_t push_entry_o,
  input  logic         push_stall_i
);

  logic [15:0] crc_init_q, crc_init_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic        accept;

  assign crc_next   = crc_byte(crc_q, data_byte_i);
  assign in_stall_o = push_stall_i;
  assign accept     = in_valid_i && !push_stall_i;

  assign push_valid_o           = in_valid_i;
  assign push_entry_o.data_byte = data_byte_i;
  assign push_entry_o.eof       = end_of_frame_i;
  assign push_entry_o.crc       = crc_next;

  always_comb begin
    crc_init_d = crc_init_q;
    crc_d      = crc_q;
    if (cfg_we_i) begin
      crc_init_d = cfg_crc_init_i;
      crc_d      = cfg_crc_init_i;
    end else if (accept) begin
      // frame end reloads the seed for the next frame
      crc_d = end_of_frame_i ? crc_init_q : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= CRC_INIT_RST;
      crc_q      <= CRC_INIT_RST;
    end else begin
      crc_init_q <= crc_init_d;
      crc_q      <= crc_d;
    end
  end

endmodule

// ===== design/crcfa_queue.sv =====
// Short FIFO between front and back ends.
`timescale 1ns / 1ps
module crcfa_queue
  import crcfa_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  crcfa_entry_t push_entry_i,
  output logic         push_stall_o,
  output logic         pop_valid_o,
  output crcfa_entry_t pop_entry_o,
  input  logic         pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  crcfa_entry_t      slots_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_stall_o = (cnt_q == CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = slots_q[rd_q];
  assign do_push      = push_valid_i && !push_stall_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/crcfa_back.sv =====
// Back end: turns each queued entry into one or three output beats.
`timescale 1ns / 1ps
`include "crc16_frame_appender_top_assert.svh"
module crcfa_back
  import crcfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  crcfa_entry_t q_entry_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic         is_crc_byte_o,
  output logic         last_of_run_o
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_HI,
    PH_LO
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        crc_flag_q, crc_flag_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    crc_flag_d  = crc_flag_q;
    last_d      = last_q;
    q_pop_o     = 1'b0;
    if (load) begin
      out_valid_d = q_valid_i;
      if (q_valid_i) begin
        case (phase_q)
          PH_DATA: begin
            byte_d     = q_entry_i.data_byte;
            crc_flag_d = 1'b0;
            last_d     = !q_entry_i.eof;
            if (q_entry_i.eof) begin
              phase_d = PH_HI;
            end else begin
              q_pop_o = 1'b1;
            end
          end
          PH_HI: begin
            byte_d     = q_entry_i.crc[15:8];
            crc_flag_d = 1'b1;
            last_d     = 1'b0;
            phase_d    = PH_LO;
          end
          PH_LO: begin
            byte_d     = q_entry_i.crc[7:0];
            crc_flag_d = 1'b1;
            last_d     = 1'b1;
            phase_d    = PH_DATA;
            q_pop_o    = 1'b1;
          end
          default: begin
            out_valid_d = 1'b0;
            phase_d     = PH_DATA;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      crc_flag_q  <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      crc_flag_q  <= crc_flag_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign is_crc_byte_o = crc_flag_q;
  assign last_of_run_o = last_q;

  // mid-sequence the entry must still sit at the queue head
  `CRCFA_NEVER(a_entry_held, clk_i, rst_ni, (phase_q != PH_DATA) && !q_valid_i, "entry lost mid-sequence")
  // a final payload byte goes out as a plain, non-closing beat with the CRC high byte next
  `CRCFA_ASSERT(a_eof_to_hi, clk_i, rst_ni, (load && q_valid_i && phase_q == PH_DATA && q_entry_i.eof) |=> (phase_q == PH_HI && out_valid_q && !last_q && !crc_flag_q), "missing CRC high byte")
  // the CRC high beat, once taken, is followed by the low beat
  `CRCFA_ASSERT(a_hi_to_lo, clk_i, rst_ni, (out_valid_q && crc_flag_q && !last_q && !out_stall_i) |=> (phase_q == PH_LO || (out_valid_q && crc_flag_q && last_q)), "CRC low byte out of order")
  // a pop only happens on a beat that closes the run
  `CRCFA_ASSERT(a_pop_last, clk_i, rst_ni, q_pop_o |=> (out_valid_q && last_q), "pop without run end")

endmodule

// ===== design/crc16_frame_appender_top.sv =====
// Top level of the CRC-16 frame appender.
//
//  channel  | dir | handshake             | beat payload
//  ---------+-----+-----------------------+------------------------------------------
//  input    | in  | in_valid_i/in_stall_o | data_byte_i, end_of_frame_i
//  output   | out | out_valid_o/out_stall_i | out_byte_o, is_crc_byte_o, last_of_run_o
//  config   | in  | cfg_we_i (no wait)    | cfg_crc_init_i (CRC seed)
//
// One input beat per cycle while the queue has room; a mid-frame byte leaves as one
// output beat, a frame-end byte as three (byte, CRC high, CRC low), so the output
// sequencer in the back end sets the sustained rate at which input beats are taken.
// Input reaches the output through the queue slot, then the output register.
// Reset (async, active low) empties the queue and loads 0xFFFF as seed and running CRC.
// A stall on the output holds the output register; the queue then fills and stalls input.
`timescale 1ns / 1ps
module crc16_frame_appender_top
  import crcfa_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_crc_init_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_crc_byte_o,
  output logic        last_of_run_o
);

  // front -> queue
  logic         push_valid;
  crcfa_entry_t push_entry;
  logic         push_stall;
  // queue -> back
  logic         q_valid;
  crcfa_entry_t q_entry;
  logic         q_pop;

  // Front: CRC runs here, each queued byte carries the CRC including itself.
  crcfa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_crc_init_i (cfg_crc_init_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .push_valid_o   (push_valid),
    .push_entry_o   (push_entry),
    .push_stall_i   (push_stall)
  );

  // Decoupling queue: lets the front keep taking beats while CRC bytes go out.
  crcfa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_stall_o (push_stall),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (q_entry),
    .pop_i        (q_pop)
  );

  // Back: serialises each entry into its output beats through the output register.
  crcfa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_crc_byte_o (is_crc_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the CRC-16 frame appender: random frames, seeds and stalls.
`timescale 1ns / 1ps
module testbench;
  import crcfa_pkg::*;

  // One payload beat on the input channel.
  typedef struct {
    logic [7:0] octet;
    logic       eof;
  } payload_beat_t;

  // One beat on the output channel: passed byte or appended CRC byte.
  typedef struct {
    logic [7:0] octet;
    logic       crc_flag;
    logic       last_flag;
  } tx_beat_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [15:0] cfg_crc_init_i = CRC_INIT_RST;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        end_of_frame_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  out_byte_o;
  logic        is_crc_byte_o;
  logic        last_of_run_o;

  crc16_frame_appender_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_crc_init_i(cfg_crc_init_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_frame_i(end_of_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_crc_byte_o (is_crc_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Payload beats waiting for the driver, and the byte stream the block owes us.
  payload_beat_t payload_q[$];
  tx_beat_t      tx_stream_q[$];

  // Shadow of the block's seed register and running frame CRC.
  logic [15:0] frame_crc_seed = CRC_INIT_RST;
  logic [15:0] frame_crc_run  = CRC_INIT_RST;

  int mismatch_count = 0;

  // Per-side gap state: cycles still to wait, and a calm flag giving runs of back-to-back beats.
  int src_gap  = 0;
  int sink_gap = 0;
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;

  // Polynomial 0x8005, MSB first, fed one message bit at a time.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] octet);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ octet[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? 16'h8005 : 16'h0000);
    end
    return acc;
  endfunction

  // Draw the wait before the next beat; now and then flip into or out of a calm run.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Work out what one accepted payload beat must produce: the byte itself, and on a
  // frame end the CRC high and low bytes, after which the frame CRC restarts from the seed.
  task automatic append_frame_beats(input logic [7:0] octet, input logic eof);
    logic [15:0] next_crc;
    next_crc = crc16_feed(frame_crc_run, octet);
    tx_stream_q.push_back('{octet, 1'b0, !eof});
    if (eof) begin
      tx_stream_q.push_back('{next_crc[15:8], 1'b1, 1'b0});
      tx_stream_q.push_back('{next_crc[7:0], 1'b1, 1'b1});
      frame_crc_run = frame_crc_seed;
    end else begin
      frame_crc_run = next_crc;
    end
  endtask

  // Input driver: a beat is taken on an edge with valid high and stall low. The next beat
  // (or the gap before it) is only set up once the current one has gone, so a stalled
  // payload never moves.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      data_byte_i    <= 8'h00;
      end_of_frame_i <= 1'b0;
      src_gap = 0;
    end else begin : drive_beat
      payload_beat_t nxt;
      logic          taken;
      taken = in_valid_i && !in_stall_o;
      if (taken) append_frame_beats(data_byte_i, end_of_frame_i);
      if (taken || !in_valid_i) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (payload_q.size() > 0) begin
          nxt = payload_q.pop_front();
          in_valid_i     <= 1'b1;
          data_byte_i    <= nxt.octet;
          end_of_frame_i <= nxt.eof;
          src_gap = draw_gap(src_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check every accepted beat against the oldest owed beat, then draw how
  // long to hold stall before the next one. Stall runs whether or not valid is up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_gap = 0;
    end else begin : watch_beat
      tx_beat_t want;
      if (out_valid_o && !out_stall_i) begin
        if (tx_stream_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected beat byte %02h crc %0b last %0b", $time,
                     out_byte_o, is_crc_byte_o, last_of_run_o);
        end else begin
          want = tx_stream_q.pop_front();
          if (out_byte_o !== want.octet || is_crc_byte_o !== want.crc_flag ||
              last_of_run_o !== want.last_flag) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: beat mismatch, expected byte %02h crc %0b last %0b, got %02h %0b %0b",
                       $time, want.octet, want.crc_flag, want.last_flag,
                       out_byte_o, is_crc_byte_o, last_of_run_o);
          end
        end
        sink_gap = draw_gap(sink_calm);
      end else if (sink_gap > 0) begin
        sink_gap--;
      end
      out_stall_i <= (sink_gap > 0);
    end
  end

  // Idle means: nothing left to send, nothing in flight, nothing owed.
  task automatic wait_idle();
    while (payload_q.size() > 0 || in_valid_i || tx_stream_q.size() > 0) @(negedge clk_i);
  endtask

  // Seed write; only issued while idle. The shadow takes the new seed at the write edge,
  // which also throws away the CRC of any half-received frame.
  task automatic write_seed(input logic [15:0] seed);
    @(posedge clk_i);
    cfg_crc_init_i <= seed;
    cfg_we_i       <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    frame_crc_seed = seed;
    frame_crc_run  = seed;
  endtask

  task automatic queue_beat(input logic [7:0] octet, input logic eof);
    payload_q.push_back('{octet, eof});
  endtask

  // Random frames, mostly short with the odd long one; if the budget runs out mid-frame the
  // frame is left open, so the following seed write has to discard it.
  task automatic queue_random_frames(input int budget);
    int         left;
    int         flen;
    logic [7:0] octet;
    left = budget;
    while (left > 0) begin
      flen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int k = 0; k < flen && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) octet = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else octet = $urandom_range(0, 255);
        queue_beat(octet, k == flen - 1);
        left--;
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] seeds[6];
    seeds = '{16'h0000, 16'hFFFF, 16'h8005, 16'h0000, 16'h0000, 16'h0001};
    seeds[3] = $urandom_range(0, 65535);
    seeds[4] = $urandom_range(0, 65535);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset seed: single-byte frames at both extremes, a frame walking the top and
    // bottom bits, alternating patterns, then a frame left open.
    @(negedge clk_i);
    queue_beat(8'h00, 1'b1);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h01, 1'b0);
    queue_beat(8'h80, 1'b0);
    queue_beat(8'h7F, 1'b0);
    queue_beat(8'hFE, 1'b1);
    queue_beat(8'hAA, 1'b0);
    queue_beat(8'h55, 1'b1);
    queue_beat(8'h12, 1'b0);
    queue_beat(8'h34, 1'b0);
    wait_idle();

    // Zero seed, written over the open frame.
    write_seed(16'h0000);
    @(negedge clk_i);
    queue_beat(8'h12, 1'b0);
    queue_beat(8'h34, 1'b1);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h00, 1'b1);
    wait_idle();

    // Back to all-ones, with another frame left open.
    write_seed(16'hFFFF);
    @(negedge clk_i);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'h00, 1'b1);
    queue_beat(8'h80, 1'b1);
    queue_beat(8'h5A, 1'b0);
    wait_idle();

    // Random part: one batch of frames per seed.
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      @(negedge clk_i);
      queue_random_frames(53);
      wait_idle();
    end

    // Drain: wait for any stray beat, then count anything still owed.
    repeat (8) @(posedge clk_i);
    if (tx_stream_q.size() > 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a fifth of this.
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
